[hw/rtl/llvt_pkg.sv]
// Shared types, constants and saturation helpers for the leg length VMC torque block.
package llvt_pkg;

   localparam int DATA_W   = 32;
   localparam int REG_W    = 31;
   localparam int NUM_REGS = 8;
   localparam int IDX_W    = 3;

   localparam logic [IDX_W-1:0] REG_KP    = 3'd0;
   localparam logic [IDX_W-1:0] REG_KI    = 3'd1;
   localparam logic [IDX_W-1:0] REG_KD    = 3'd2;
   localparam logic [IDX_W-1:0] REG_ILIM  = 3'd3;
   localparam logic [IDX_W-1:0] REG_FLIM  = 3'd4;
   localparam logic [IDX_W-1:0] REG_DT    = 3'd5;
   localparam logic [IDX_W-1:0] REG_RETR  = 3'd6;
   localparam logic [IDX_W-1:0] REG_RGAIN = 3'd7;

   localparam logic [REG_W-1:0] REG_RESET [NUM_REGS] = '{
      31'd39321600, 31'd6553600, 31'd7864320, 31'd3932160,
      31'd9830400, 31'd131, 31'd655360, 31'd3932160
   };

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LAUNCH,
      ST_WAIT,
      ST_OUT
   } llvt_state_type;

   typedef enum logic [3:0] {
      OP_KP_ERR,
      OP_KD_SPD,
      OP_RG_RATE,
      OP_KI_ERR,
      OP_IE_DT,
      OP_DIV_X,
      OP_DIV_Z,
      OP_DIV_T,
      OP_AX_RX,
      OP_TN_RZ,
      OP_AX_RZ,
      OP_TN_RX,
      OP_JXA_FX,
      OP_JZA_FZ,
      OP_JXB_FX,
      OP_JZB_FZ
   } llvt_op_type;

   localparam logic signed [DATA_W-1:0] S32_MAX = 32'sh7fff_ffff;
   localparam logic signed [DATA_W-1:0] S32_MIN = 32'sh8000_0000;

   function automatic logic signed [DATA_W-1:0] sat33(input logic signed [DATA_W:0] v);
      logic signed [DATA_W-1:0] r;
      if (v[DATA_W] != v[DATA_W-1]) begin
         r = v[DATA_W] ? S32_MIN : S32_MAX;
      end else begin
         r = v[DATA_W-1:0];
      end
      return r;
   endfunction

   function automatic logic signed [DATA_W-1:0] sat36(input logic signed [DATA_W+3:0] v);
      logic signed [DATA_W-1:0] r;
      if (v > 36'sh0_7fff_ffff) begin
         r = S32_MAX;
      end else if (v < -36'sh0_8000_0000) begin
         r = S32_MIN;
      end else begin
         r = v[DATA_W-1:0];
      end
      return r;
   endfunction

   function automatic logic signed [DATA_W-1:0] clamp_sym(
         input logic signed [DATA_W-1:0] v, input logic [REG_W-1:0] lim);
      logic signed [DATA_W-1:0] plim;
      logic signed [DATA_W-1:0] r;
      plim = $signed({1'b0, lim});
      if (v > plim) begin
         r = plim;
      end else if (v < -plim) begin
         r = -plim;
      end else begin
         r = v;
      end
      return r;
   endfunction

endpackage

[hw/rtl/leg_length_vmc_torque.sv]
// Top level: leg length virtual-model controller with Jacobian-transpose torque mapping.
// One request is worked on at a time by a sequencer driving a bit-serial multiplier
// and a restoring divider. A request takes 5 products, 3 quotients and 8 more
// products plus an accept and an output step; when leg_length is not positive it
// takes only the 5 products (no divisions, no torque products). The next request is
// taken as soon as the previous result sits in the output register; the integral is
// applied before its update.
module leg_length_vmc_torque
   import llvt_pkg::*;
#(
   parameter int FRAC_BITS = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   // leg_length, foot_x, foot_z, jac_xa, jac_xb, jac_za, jac_zb, target_length,
   // support_ff, angle_torque, leg_speed, target_rate (32 bits each, from bit 0 up)
   input  logic [383:0]        req_tdata,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   // leg_force, torque_joint0, torque_joint1 (32 bits each, from bit 0 up)
   output logic [95:0]         rsp_tdata,
   // length_fault
   output logic                rsp_tuser,
   input  logic                csr_we,
   input  logic [IDX_W-1:0]    csr_index,
   input  logic [REG_W-1:0]    csr_wdata
);

   localparam logic signed [DATA_W-1:0] RETRACT_BAND =
      32'(((3 << FRAC_BITS) + 500) / 1000);
   localparam logic signed [DATA_W-1:0] RATE_BAND =
      32'(((5 << FRAC_BITS) + 500) / 1000);

   llvt_state_type state_ff, state_in;
   llvt_op_type    op_ff, op_in;

   logic [REG_W-1:0] cfg_ff [NUM_REGS];
   logic [383:0]     in_ff;
   logic signed [DATA_W-1:0] err_ff, integ_ff, axial_ff;
   logic signed [DATA_W-1:0] pa_ff, pb_ff, pc_ff, ie_ff;
   logic signed [DATA_W-1:0] rx_ff, rz_ff, tan_ff, fx_ff, fz_ff, t0_ff, t1_ff;
   logic fault_ff;

   logic        rsp_tvalid_ff;
   logic [95:0] rsp_tdata_ff;
   logic        rsp_tuser_ff;

   logic signed [DATA_W-1:0] len, fx_off, fz_off, jxa, jxb, jza, jzb;
   logic signed [DATA_W-1:0] support, ang_t, speed, rate;
   logic signed [DATA_W-1:0] req_len, req_target;
   logic signed [DATA_W:0]   req_diff;

   logic        mul_start, div_start, mul_done, div_done, is_div, unit_done;
   logic signed [DATA_W-1:0] mul_a, mul_b, mul_res, div_res, div_num;

   logic signed [DATA_W+3:0] sum;
   logic signed [DATA_W-1:0] axial_new, integ_new;

   assign len     = in_ff[31:0];
   assign fx_off  = in_ff[63:32];
   assign fz_off  = in_ff[95:64];
   assign jxa     = in_ff[127:96];
   assign jxb     = in_ff[159:128];
   assign jza     = in_ff[191:160];
   assign jzb     = in_ff[223:192];
   assign support = in_ff[287:256];
   assign ang_t   = in_ff[319:288];
   assign speed   = in_ff[351:320];
   assign rate    = in_ff[383:352];

   assign req_len    = req_tdata[31:0];
   assign req_target = req_tdata[255:224];
   assign req_diff   = {req_target[DATA_W-1], req_target} - {req_len[DATA_W-1], req_len};

   assign req_tready = (state_ff == ST_IDLE);
   assign is_div     = (op_ff == OP_DIV_X) || (op_ff == OP_DIV_Z) || (op_ff == OP_DIV_T);
   assign unit_done  = is_div ? div_done : mul_done;

   llvt_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
      .clock (clock), .reset (reset), .start (mul_start),
      .op_a (mul_a), .op_b (mul_b), .done (mul_done), .result (mul_res)
   );

   llvt_div #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clock (clock), .reset (reset), .start (div_start),
      .num (div_num), .den (len), .done (div_done), .result (div_res)
   );

   // operand select per step
   always_comb begin
      mul_a   = '0;
      mul_b   = '0;
      div_num = '0;
      unique case (op_ff)
         OP_KP_ERR:  begin mul_a = $signed({1'b0, cfg_ff[REG_KP]});    mul_b = err_ff; end
         OP_KD_SPD:  begin mul_a = $signed({1'b0, cfg_ff[REG_KD]});    mul_b = speed;  end
         OP_RG_RATE: begin mul_a = $signed({1'b0, cfg_ff[REG_RGAIN]}); mul_b = rate;   end
         OP_KI_ERR:  begin mul_a = $signed({1'b0, cfg_ff[REG_KI]});    mul_b = err_ff; end
         OP_IE_DT:   begin mul_a = ie_ff; mul_b = $signed({1'b0, cfg_ff[REG_DT]}); end
         OP_DIV_X:   div_num = fx_off;
         OP_DIV_Z:   div_num = fz_off;
         OP_DIV_T:   div_num = ang_t;
         OP_AX_RX:   begin mul_a = axial_ff; mul_b = rx_ff; end
         OP_TN_RZ:   begin mul_a = tan_ff;   mul_b = rz_ff; end
         OP_AX_RZ:   begin mul_a = axial_ff; mul_b = rz_ff; end
         OP_TN_RX:   begin mul_a = tan_ff;   mul_b = rx_ff; end
         OP_JXA_FX:  begin mul_a = jxa; mul_b = fx_ff; end
         OP_JZA_FZ:  begin mul_a = jza; mul_b = fz_ff; end
         OP_JXB_FX:  begin mul_a = jxb; mul_b = fx_ff; end
         OP_JZB_FZ:  begin mul_a = jzb; mul_b = fz_ff; end
         default:    ;
      endcase
   end

   // axial force and integral update, formed when the last first-phase product lands
   always_comb begin
      sum = 36'(pa_ff) - 36'(pb_ff) + 36'(support) + 36'(integ_ff);
      if (err_ff < -RETRACT_BAND) begin
         sum = sum - $signed({5'b0, cfg_ff[REG_RETR]});
      end
      if (rate > RATE_BAND) begin
         sum = sum + 36'(pc_ff);
      end
      axial_new = clamp_sym(sat36(sum), cfg_ff[REG_FLIM]);
      integ_new = clamp_sym(sat33({integ_ff[DATA_W-1], integ_ff}
                                  + {mul_res[DATA_W-1], mul_res}), cfg_ff[REG_ILIM]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         op_ff    <= OP_KP_ERR;
      end else begin
         state_ff <= state_in;
         op_ff    <= op_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      op_in     = op_ff;
      mul_start = 1'b0;
      div_start = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = ST_LAUNCH;
               op_in    = OP_KP_ERR;
            end
         end
         ST_LAUNCH: begin
            mul_start = !is_div;
            div_start = is_div;
            state_in  = ST_WAIT;
         end
         ST_WAIT: begin
            if (unit_done) begin
               if (op_ff == OP_JZB_FZ || (op_ff == OP_IE_DT && fault_ff)) begin
                  state_in = ST_OUT;
               end else begin
                  state_in = ST_LAUNCH;
                  op_in    = llvt_op_type'(op_ff + 4'd1);
               end
            end
         end
         ST_OUT: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // configuration registers and integral state
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_REGS; i++) begin
            cfg_ff[i] <= REG_RESET[i];
         end
         integ_ff <= '0;
      end else begin
         if (csr_we) begin
            cfg_ff[csr_index] <= csr_wdata;
         end
         if (state_ff == ST_WAIT && mul_done && op_ff == OP_IE_DT) begin
            integ_ff <= integ_new;
         end
      end
   end

   // datapath: capture the request, then write back each step
   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && req_tvalid) begin
         in_ff    <= req_tdata;
         err_ff   <= sat33(req_diff);
         fault_ff <= (req_len <= 0);
         t0_ff    <= '0;
         t1_ff    <= '0;
      end
      if (state_ff == ST_WAIT && unit_done) begin
         unique case (op_ff)
            OP_KP_ERR:  pa_ff <= mul_res;
            OP_KD_SPD:  pb_ff <= mul_res;
            OP_RG_RATE: pc_ff <= mul_res;
            OP_KI_ERR:  ie_ff <= mul_res;
            OP_IE_DT:   axial_ff <= axial_new;
            OP_DIV_X:   rx_ff <= div_res;
            OP_DIV_Z:   rz_ff <= div_res;
            OP_DIV_T:   tan_ff <= div_res;
            OP_AX_RX:   pa_ff <= mul_res;
            OP_TN_RZ:   fx_ff <= sat33({pa_ff[DATA_W-1], pa_ff} - {mul_res[DATA_W-1], mul_res});
            OP_AX_RZ:   pa_ff <= mul_res;
            OP_TN_RX:   fz_ff <= sat33({pa_ff[DATA_W-1], pa_ff} + {mul_res[DATA_W-1], mul_res});
            OP_JXA_FX:  pa_ff <= mul_res;
            OP_JZA_FZ:  t0_ff <= sat33({pa_ff[DATA_W-1], pa_ff} + {mul_res[DATA_W-1], mul_res});
            OP_JXB_FX:  pa_ff <= mul_res;
            OP_JZB_FZ:  t1_ff <= sat33({pa_ff[DATA_W-1], pa_ff} + {mul_res[DATA_W-1], mul_res});
            default:    ;
         endcase
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (state_ff == ST_OUT && (!rsp_tvalid_ff || rsp_tready)) begin
         rsp_tvalid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_OUT && (!rsp_tvalid_ff || rsp_tready)) begin
         rsp_tdata_ff <= {t1_ff, t0_ff, axial_ff};
         rsp_tuser_ff <= fault_ff;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

   a_one_unit: assert property (@(posedge clock) disable iff (reset)
      !(mul_start && div_start))
      else $error("multiplier and divider started together");

   a_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      (mul_done || div_done) |-> state_ff == ST_WAIT)
      else $error("unit finished outside the wait state");

   a_fault_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> rsp_tdata[95:32] == 64'd0)
      else $error("fault result carries nonzero torques");

   a_start_after_launch: assert property (@(posedge clock) disable iff (reset)
      (mul_start || div_start) |=> state_ff == ST_WAIT)
      else $error("unit start not followed by wait");

endmodule

[hw/rtl/llvt_mul.sv]
// Bit-serial signed fractional multiplier: floor shift by FRAC_BITS, saturated to 32 bits.
module llvt_mul
   import llvt_pkg::*;
#(
   parameter int FRAC_BITS = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic signed [DATA_W-1:0] op_a,
   input  logic signed [DATA_W-1:0] op_b,
   output logic                     done,
   output logic signed [DATA_W-1:0] result
);

   localparam int HI_W = 2*DATA_W - FRAC_BITS - DATA_W + 1;

   logic [DATA_W-1:0]   mcand_ff;
   logic [2*DATA_W-1:0] prod_ff;
   logic                neg_ff;
   logic                busy_ff;
   logic                fin_ff;
   logic                done_ff;
   logic [4:0]          cnt_ff;
   logic signed [DATA_W-1:0] result_ff;

   logic [DATA_W:0]          sum_hi;
   logic signed [2*DATA_W-1:0] sprod;
   logic [HI_W-1:0]          top;

   assign sum_hi = {1'b0, prod_ff[2*DATA_W-1:DATA_W]}
                 + (prod_ff[0] ? {1'b0, mcand_ff} : {(DATA_W+1){1'b0}});
   assign sprod  = neg_ff ? -$signed(prod_ff) : $signed(prod_ff);
   assign top    = sprod[2*DATA_W-1:DATA_W+FRAC_BITS-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         fin_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         fin_ff  <= !start && busy_ff && (cnt_ff == 5'd31);
         done_ff <= !start && !busy_ff && fin_ff;
         if (start) begin
            mcand_ff <= op_a[DATA_W-1] ? (~op_a + 1'b1) : op_a;
            prod_ff  <= {{DATA_W{1'b0}}, (op_b[DATA_W-1] ? (~op_b + 1'b1) : op_b)};
            neg_ff   <= op_a[DATA_W-1] ^ op_b[DATA_W-1];
            cnt_ff   <= '0;
            busy_ff  <= 1'b1;
         end else if (busy_ff) begin
            // add and shift one multiplier bit
            prod_ff <= {sum_hi, prod_ff[DATA_W-1:1]};
            cnt_ff  <= cnt_ff + 5'd1;
            if (cnt_ff == 5'd31) begin
               busy_ff <= 1'b0;
            end
         end else if (fin_ff) begin
            if (top != {HI_W{1'b0}} && top != {HI_W{1'b1}}) begin
               result_ff <= sprod[2*DATA_W-1] ? S32_MIN : S32_MAX;
            end else begin
               result_ff <= sprod[DATA_W+FRAC_BITS-1:FRAC_BITS];
            end
         end
      end
   end

   assign done   = done_ff;
   assign result = result_ff;

endmodule

[hw/rtl/llvt_div.sv]
// Restoring bit-serial divider: (a << FRAC_BITS) / d toward zero, d positive, saturated.
module llvt_div
   import llvt_pkg::*;
#(
   parameter int FRAC_BITS = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic signed [DATA_W-1:0] num,
   input  logic signed [DATA_W-1:0] den,
   output logic                     done,
   output logic signed [DATA_W-1:0] result
);

   localparam int N  = DATA_W + FRAC_BITS;
   localparam int CW = $clog2(N);
   localparam logic [N-1:0] QPOS = {{(N-DATA_W){1'b0}}, 32'h7fff_ffff};
   localparam logic [N-1:0] QNEG = {{(N-DATA_W){1'b0}}, 32'h8000_0000};

   logic [N-1:0]      dv_ff;
   logic [N-1:0]      q_ff;
   logic [DATA_W-1:0] rem_ff;
   logic [DATA_W-1:0] den_ff;
   logic              neg_ff;
   logic              busy_ff;
   logic              fin_ff;
   logic              done_ff;
   logic [CW-1:0]     cnt_ff;
   logic signed [DATA_W-1:0] result_ff;

   logic [DATA_W:0] trial;
   logic            ge;
   logic [DATA_W:0] diff;

   assign trial = {rem_ff, dv_ff[N-1]};
   assign ge    = trial >= {1'b0, den_ff};
   assign diff  = trial - {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         fin_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         fin_ff  <= !start && busy_ff && (cnt_ff == CW'(N-1));
         done_ff <= !start && !busy_ff && fin_ff;
         if (start) begin
            dv_ff   <= {(num[DATA_W-1] ? (~num + 1'b1) : num), {FRAC_BITS{1'b0}}};
            q_ff    <= '0;
            rem_ff  <= '0;
            den_ff  <= den;
            neg_ff  <= num[DATA_W-1];
            cnt_ff  <= '0;
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            // one quotient bit per cycle
            rem_ff <= ge ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
            q_ff   <= {q_ff[N-2:0], ge};
            dv_ff  <= {dv_ff[N-2:0], 1'b0};
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CW'(N-1)) begin
               busy_ff <= 1'b0;
            end
         end else if (fin_ff) begin
            if (!neg_ff && q_ff > QPOS) begin
               result_ff <= S32_MAX;
            end else if (neg_ff && q_ff > QNEG) begin
               result_ff <= S32_MIN;
            end else if (neg_ff) begin
               result_ff <= -$signed(q_ff[DATA_W-1:0]);
            end else begin
               result_ff <= q_ff[DATA_W-1:0];
            end
         end
      end
   end

   assign done   = done_ff;
   assign result = result_ff;

endmodule

[tb/leg_length_vmc_torque_test.sv]
// Self-checking testbench for the leg length VMC torque block: directed and random streams against a predictor.
module leg_length_vmc_torque_test
   import llvt_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int FRAC = 16;
   localparam int RETRACT_BAND = 197;
   localparam int RATE_BAND = 328;
   localparam int IDLE_LIMIT = 20000;
   localparam int RAND_ITEMS = 1200;

   typedef struct packed {
      logic signed [31:0] target_rate;
      logic signed [31:0] leg_speed;
      logic signed [31:0] angle_torque;
      logic signed [31:0] support_ff;
      logic signed [31:0] target_length;
      logic signed [31:0] jac_zb;
      logic signed [31:0] jac_za;
      logic signed [31:0] jac_xb;
      logic signed [31:0] jac_xa;
      logic signed [31:0] foot_z;
      logic signed [31:0] foot_x;
      logic signed [31:0] leg_length;
   } leg_request_type;

   typedef struct {
      logic signed [31:0] axial;
      logic signed [31:0] tq0;
      logic signed [31:0] tq1;
      logic               fault;
   } torque_result_type;

   class torque_scoreboard;
      torque_result_type pending_q[$];
      longint gains[NUM_REGS];
      longint integral_acc;
      int     mismatches;
      int     faults_seen;
      int     checked;

      function new();
         for (int i = 0; i < NUM_REGS; i++) gains[i] = REG_RESET[i];
         integral_acc = 0;
         mismatches = 0;
         faults_seen = 0;
         checked = 0;
      endfunction

      function longint sat(longint v);
         if (v > 64'sd2147483647) return 64'sd2147483647;
         if (v < -64'sd2147483648) return -64'sd2147483648;
         return v;
      endfunction

      function longint clamp(longint v, longint lim);
         if (v > lim) return lim;
         if (v < -lim) return -lim;
         return v;
      endfunction

      // floor of the scaled product
      function longint qmul(longint a, longint b);
         longint p;
         p = a * b;
         return sat(p >>> FRAC);
      endfunction

      function longint qdiv(longint a, longint d);
         return sat((a * (64'sd1 <<< FRAC)) / d);
      endfunction

      function void set_reg(logic [IDX_W-1:0] idx, logic [REG_W-1:0] val);
         gains[idx] = val;
      endfunction

      function void note_request(leg_request_type it);
         longint len, err, sum, axial, rx, rz, tf, fx, fz, t0, t1;
         torque_result_type r;
         len = it.leg_length;
         t0 = 0;
         t1 = 0;
         err = sat(longint'(it.target_length) - len);
         sum = qmul(gains[REG_KP], err) - qmul(gains[REG_KD], it.leg_speed)
               + longint'(it.support_ff) + integral_acc;
         if (err < -RETRACT_BAND) sum -= gains[REG_RETR];
         if (it.target_rate > RATE_BAND) sum += qmul(gains[REG_RGAIN], it.target_rate);
         axial = clamp(sat(sum), gains[REG_FLIM]);
         if (len > 0) begin
            rx = qdiv(it.foot_x, len);
            rz = qdiv(it.foot_z, len);
            tf = qdiv(it.angle_torque, len);
            fx = sat(qmul(axial, rx) - qmul(tf, rz));
            fz = sat(qmul(axial, rz) + qmul(tf, rx));
            t0 = sat(qmul(it.jac_xa, fx) + qmul(it.jac_za, fz));
            t1 = sat(qmul(it.jac_xb, fx) + qmul(it.jac_zb, fz));
         end
         r.axial = axial[31:0];
         r.tq0 = t0[31:0];
         r.tq1 = t1[31:0];
         r.fault = (len <= 0);
         pending_q.push_back(r);
         // integral is applied above, then updated
         integral_acc = clamp(sat(integral_acc
                        + qmul(qmul(gains[REG_KI], err), gains[REG_DT])), gains[REG_ILIM]);
      endfunction

      function void check_result(logic [95:0] data, logic fault);
         torque_result_type e;
         checked++;
         if (fault) faults_seen++;
         if (pending_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("ERROR: unexpected result %h fault %b", data, fault);
            return;
         end
         e = pending_q.pop_front();
         if (data[31:0] !== e.axial || data[63:32] !== e.tq0 || data[95:64] !== e.tq1
             || fault !== e.fault) begin
            mismatches++;
            if (mismatches <= 10)
               $display("ERROR: result %0d exp axial %h t0 %h t1 %h fault %b, got %h %h %h %b",
                        checked, e.axial, e.tq0, e.tq1, e.fault,
                        data[31:0], data[63:32], data[95:64], fault);
         end
      endfunction
   endclass

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [383:0]      req_tdata = '0;
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [95:0]       rsp_tdata;
   logic              rsp_tuser;
   logic              csr_we = 1'b0;
   logic [IDX_W-1:0]  csr_index = REG_KP;
   logic [REG_W-1:0]  csr_wdata = '0;

   torque_scoreboard sb = new();
   int idle_cycles = 0;
   int sent = 0;
   int burst_left = 0;

   always #1 clock = ~clock;

   leg_length_vmc_torque #(.FRAC_BITS(FRAC)) u_top (.*);

   always @(posedge clock) begin
      if (rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata, rsp_tuser);
      if ((rsp_tvalid && rsp_tready) || (req_tvalid && req_tready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("watchdog: no handshake for %0d cycles", IDLE_LIMIT);
         $display("FAIL leg_length_vmc_torque");
         $finish;
      end
   end

   // receiver stall pattern steps through three modes in turn
   int rx_cycle = 0;
   int rx_hold = 0;
   always @(negedge clock) begin
      rx_cycle++;
      if (rx_hold > 0) begin
         rx_hold--;
         rsp_tready <= 1'b0;
      end else begin
         case ((rx_cycle / 256) % 3)
            0: rsp_tready <= 1'b1;
            1: rsp_tready <= ($urandom_range(0, 3) != 0);
            default: begin
               rsp_tready <= 1'b1;
               if ($urandom_range(0, 7) == 0) rx_hold = $urandom_range(1, 30);
            end
         endcase
      end
   end

   function automatic int srand(int span);
      return $signed($urandom_range(0, 2 * span)) - span;
   endfunction

   function automatic logic [31:0] edge_val();
      case ($urandom_range(0, 5))
         0: return 32'h0;
         1: return 32'h1;
         2: return 32'hffff_ffff;
         3: return 32'h7fff_ffff;
         4: return 32'h8000_0000;
         default: return $urandom;
      endcase
   endfunction

   function automatic leg_request_type random_request();
      leg_request_type it;
      int sel;
      sel = $urandom_range(0, 99);
      if (sel < 60) begin
         it.leg_length = $urandom_range(6554, 39322);
         it.foot_x = srand(13107);
         it.foot_z = -$signed($urandom_range(6554, 39322));
         it.jac_xa = srand(19661);
         it.jac_xb = srand(19661);
         it.jac_za = srand(19661);
         it.jac_zb = srand(19661);
         it.target_length = it.leg_length + srand(6554);
         it.support_ff = srand(1310720);
         it.angle_torque = srand(327680);
         it.leg_speed = srand(131072);
         it.target_rate = srand(65536);
         if ($urandom_range(0, 19) == 0) it.leg_length = -$signed($urandom_range(0, 655));
      end else if (sel < 85) begin
         it = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
               $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      end else begin
         it = {edge_val(), edge_val(), edge_val(), edge_val(), edge_val(), edge_val(),
               edge_val(), edge_val(), edge_val(), edge_val(), edge_val(), edge_val()};
      end
      return it;
   endfunction

   task automatic send_request(leg_request_type it);
      if (burst_left == 0) begin
         repeat ($urandom_range(0, 3) == 0 ? $urandom_range(1, 40) : 0) @(negedge clock);
         burst_left = $urandom_range(1, 12);
      end
      burst_left--;
      req_tvalid = 1'b1;
      req_tdata = it;
      forever begin
         @(posedge clock);
         if (req_tready) break;
      end
      sb.note_request(it);
      sent++;
      @(negedge clock);
      req_tvalid = 1'b0;
   endtask

   task automatic write_reg(logic [IDX_W-1:0] idx, logic [REG_W-1:0] val);
      csr_we = 1'b1;
      csr_index = idx;
      csr_wdata = val;
      @(posedge clock);
      sb.set_reg(idx, val);
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   task automatic drain();
      while (sb.pending_q.size() > 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic set_regs(logic [REG_W-1:0] kp, logic [REG_W-1:0] ki,
                           logic [REG_W-1:0] kd, logic [REG_W-1:0] ilim,
                           logic [REG_W-1:0] flim, logic [REG_W-1:0] dt,
                           logic [REG_W-1:0] retr, logic [REG_W-1:0] rg);
      drain();
      write_reg(REG_KP, kp);
      write_reg(REG_KI, ki);
      write_reg(REG_KD, kd);
      write_reg(REG_ILIM, ilim);
      write_reg(REG_FLIM, flim);
      write_reg(REG_DT, dt);
      write_reg(REG_RETR, retr);
      write_reg(REG_RGAIN, rg);
   endtask

   task automatic directed_requests();
      leg_request_type it;
      it = random_request();
      it.leg_length = 16384;
      it.foot_x = 4000;
      it.foot_z = -15000;
      send_request(it);
      send_request('0);
      send_request({12{32'h7fff_ffff}});
      send_request({12{32'h8000_0000}});
      send_request({12{32'hffff_ffff}});
      it.leg_length = 0;
      send_request(it);
      it.leg_length = 1;
      send_request(it);
      it.leg_length = 32'h8000_0000;
      send_request(it);
      // retract deadband edge, then one past it
      it.leg_length = 20000;
      it.target_length = 20000 - RETRACT_BAND;
      send_request(it);
      it.target_length = 20000 - RETRACT_BAND - 1;
      send_request(it);
      // rate deadband edge, then one past it
      it.target_length = 20000;
      it.target_rate = RATE_BAND;
      send_request(it);
      it.target_rate = RATE_BAND + 1;
      send_request(it);
      // saturating error and tiny length to overflow quotients
      it.leg_length = 1;
      it.target_length = 32'h8000_0000;
      it.foot_x = 32'h7fff_ffff;
      it.foot_z = 32'h8000_0000;
      it.angle_torque = 32'h7fff_ffff;
      send_request(it);
      // integral builds up and saturates
      for (int i = 0; i < 10; i++) begin
         it = random_request();
         it.leg_length = 13107;
         it.target_length = 26214;
         send_request(it);
      end
   endtask

   task automatic random_phase(int n);
      for (int i = 0; i < n; i++) send_request(random_request());
   endtask

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      directed_requests();
      random_phase(RAND_ITEMS / 8);
      set_regs('1, '1, '1, '1, '1, '1, '1, '1);
      directed_requests();
      random_phase(RAND_ITEMS / 8);
      set_regs('0, '0, '0, '0, '0, '0, '0, '0);
      random_phase(RAND_ITEMS / 8);
      set_regs($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      random_phase(RAND_ITEMS / 8);
      // strong integral with a wide limit, then the limit lowered
      set_regs(3932160, 6553600, 655360, 7864320, 13107200, 6554, 1310720, 655360);
      random_phase(RAND_ITEMS / 8);
      set_regs(3932160, 6553600, 655360, 65536, 13107200, 6554, 1310720, 655360);
      random_phase(RAND_ITEMS / 8);
      set_regs($urandom_range(0, 65536000), $urandom_range(0, 65536000),
               $urandom_range(0, 6553600), $urandom_range(0, 6553600),
               $urandom_range(0, 6553600), $urandom_range(0, 655),
               $urandom_range(0, 1310720), $urandom_range(0, 6553600));
      random_phase(RAND_ITEMS / 8);
      set_regs(39321600, 6553600, 7864320, 3932160, 9830400, 131, 655360, 3932160);
      random_phase(RAND_ITEMS / 8);
      while (sb.pending_q.size() > 0) @(negedge clock);
      repeat (600) @(negedge clock);
      $display("Sent %0d requests over 8 register settings; %0d results checked, %0d faults.",
               sent, sb.checked, sb.faults_seen);
      if (sb.mismatches == 0 && sb.pending_q.size() == 0) begin
         $display("PASS leg_length_vmc_torque");
      end else begin
         $display("%0d mismatches, %0d results missing", sb.mismatches, sb.pending_q.size());
         $display("FAIL leg_length_vmc_torque");
      end
      $finish;
   end
endmodule

[filelist.f]
hw/rtl/llvt_pkg.sv
hw/rtl/llvt_mul.sv
hw/rtl/llvt_div.sv
hw/rtl/leg_length_vmc_torque.sv
tb/leg_length_vmc_torque_test.sv
